// File: rtl/atgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atgm_pkg
// Shared widths and the gamma threshold table for the tone map pipeline.
// ----------------------------------------------------------------------------
package atgm_pkg;

  localparam int HDR_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int CODE_W  = 8;
  localparam int Q_W     = 16;
  localparam int T_W     = 33;   // 251*x + 3*one and 243*x + 59*one
  localparam int DEN_W   = 58;   // x*t + 14*one^2
  localparam int DIV_STEPS = Q_W;
  localparam int GAM_STEPS = CODE_W;
  localparam int GAIN_SHIFT = 12;

  typedef logic [HDR_W-1:0]  hdr_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [Q_W:0]      thr_t;
  typedef thr_t              thr_tab_t [256];

  // Smallest q with q^5 * 510^11 >= 65536^5 * (2c-1)^11, 65536 when none.
  function automatic thr_t gamma_thr(input int c);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int lo;
    int hi;
    int mid;
    if (c == 0) begin
      return '0;
    end
    rhs = 192'(1) << 80;
    for (int k = 0; k < 11; k++) begin
      rhs = rhs * 192'(2 * c - 1);
    end
    lo = 0;
    hi = 65536;
    for (int it = 0; it < 17; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        lhs = 192'(1);
        for (int k = 0; k < 5; k++) begin
          lhs = lhs * 192'(mid);
        end
        for (int k = 0; k < 11; k++) begin
          lhs = lhs * 192'(510);
        end
        if (lhs >= rhs) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return thr_t'(lo);
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = gamma_thr(c);
    end
    return tab;
  endfunction

  localparam thr_tab_t GAMMA_THR = build_thr();

endpackage
`default_nettype wire

// File: rtl/atgm_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atgm_lane
// One color channel: exposure, filmic fit, divider and gamma code search.
// ----------------------------------------------------------------------------
module atgm_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire atgm_pkg::hdr_t  hdr,
  input  wire atgm_pkg::gain_t gain,
  output atgm_pkg::code_t     code
);
  import atgm_pkg::*;

  localparam logic [T_W-1:0]   ONE3  = T_W'(3) << FRAC_BITS;
  localparam logic [T_W-1:0]   ONE59 = T_W'(59) << FRAC_BITS;
  localparam logic [DEN_W-1:0] K14   = DEN_W'(14) << (2 * FRAC_BITS);

  // exposure scale with saturation
  logic [HDR_W+GAIN_W-1:0] prod;
  hdr_t e;
  assign prod = (HDR_W+GAIN_W)'(hdr) * (HDR_W+GAIN_W)'(gain);
  always_ff @(posedge clk) begin
    if (en) begin
      if (prod[HDR_W+GAIN_W-1:HDR_W+GAIN_SHIFT] != '0) e <= '1;
      else e <= prod[HDR_W+GAIN_SHIFT-1:GAIN_SHIFT];
    end
  end

  // inner linear terms
  hdr_t e2;
  logic [T_W-1:0] t1, t2;
  always_ff @(posedge clk) begin
    if (en) begin
      e2 <= e;
      t1 <= T_W'(e) * T_W'(251) + ONE3;
      t2 <= T_W'(e) * T_W'(243) + ONE59;
    end
  end

  // partial products, operand split in two halves
  logic [40:0] n_lo, d_lo;
  logic [39:0] n_hi, d_hi;
  always_ff @(posedge clk) begin
    if (en) begin
      n_lo <= 41'(e2) * 41'(t1[16:0]);
      n_hi <= 40'(e2) * 40'(t1[32:17]);
      d_lo <= 41'(e2) * 41'(t2[16:0]);
      d_hi <= 40'(e2) * 40'(t2[32:17]);
    end
  end

  // numerator, denominator and the clamp at one
  logic [DEN_W-1:0] num_c, den_c;
  assign num_c = (DEN_W'(n_hi) << 17) + DEN_W'(n_lo);
  assign den_c = (DEN_W'(d_hi) << 17) + DEN_W'(d_lo) + K14;

  logic [DEN_W:0]   rem [DIV_STEPS+1];
  logic [DEN_W-1:0] den [DIV_STEPS+1];
  logic [Q_W-1:0]   quo [DIV_STEPS+1];
  logic             sat [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, num_c};
      den[0] <= den_c;
      quo[0] <= '0;
      sat[0] <= num_c >= den_c;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [DEN_W:0] r2;
    assign r2 = {rem[s][DEN_W-1:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        den[s+1] <= den[s];
        sat[s+1] <= sat[s];
        if (r2 >= {1'b0, den[s]}) begin
          rem[s+1] <= r2 - {1'b0, den[s]};
          quo[s+1] <= {quo[s][Q_W-2:0], 1'b1};
        end else begin
          rem[s+1] <= r2;
          quo[s+1] <= {quo[s][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  logic [Q_W-1:0] q_fin;
  assign q_fin = sat[DIV_STEPS] ? '1 : quo[DIV_STEPS];

  // gamma code search, one code bit per stage, MSB first
  logic [Q_W-1:0] gq [GAM_STEPS+1];
  code_t          gc [GAM_STEPS+1];
  assign gq[0] = q_fin;
  assign gc[0] = '0;
  for (genvar s = 0; s < GAM_STEPS; s++) begin : g_gam
    code_t cand;
    assign cand = gc[s] | (code_t'(1) << (GAM_STEPS - 1 - s));
    always_ff @(posedge clk) begin
      if (en) begin
        gq[s+1] <= gq[s];
        if ({1'b0, gq[s]} >= GAMMA_THR[cand]) gc[s+1] <= cand;
        else gc[s+1] <= gc[s];
      end
    end
  end

  assign code = gc[GAM_STEPS];

endmodule
`default_nettype wire

// File: rtl/aces_tonemap_gamma_encode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aces_tonemap_gamma_encode
// ACES filmic tone map, gamma 1/2.2 encode; one RGB pixel per unstalled clock.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls; its codes pass the
// exposure, linear-term, product and divider-input registers, a 16-stage
// divider giving one quotient bit per stage, and an 8-stage search of the
// gamma threshold table giving one code bit per stage. Three identical
// lanes run in lockstep, one per channel. A stall at the output freezes
// the whole pipeline. The exposure gain is written through exposure_gain_we.
module aces_tonemap_gamma_encode #(
  parameter int INPUT_FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire atgm_pkg::hdr_t  hdr_red,
  input  wire atgm_pkg::hdr_t  hdr_green,
  input  wire atgm_pkg::hdr_t  hdr_blue,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output atgm_pkg::code_t      code_red,
  output atgm_pkg::code_t      code_green,
  output atgm_pkg::code_t      code_blue,
  input  wire logic            exposure_gain_we,
  input  wire atgm_pkg::gain_t exposure_gain_wdata
);
  import atgm_pkg::*;

  localparam int LAT = 4 + DIV_STEPS + GAM_STEPS;

  gain_t exposure_gain;
  logic [LAT-1:0] vld;
  logic en;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  // gain register
  always_ff @(posedge clk) begin
    if (rst) exposure_gain <= gain_t'(4096);
    else if (exposure_gain_we) exposure_gain <= exposure_gain_wdata;
  end

  // request tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  atgm_lane #(.FRAC_BITS(INPUT_FRAC_BITS)) u_red (
    .clk(clk), .en(en), .hdr(hdr_red), .gain(exposure_gain), .code(code_red)
  );
  atgm_lane #(.FRAC_BITS(INPUT_FRAC_BITS)) u_green (
    .clk(clk), .en(en), .hdr(hdr_green), .gain(exposure_gain), .code(code_green)
  );
  atgm_lane #(.FRAC_BITS(INPUT_FRAC_BITS)) u_blue (
    .clk(clk), .en(en), .hdr(hdr_blue), .gain(exposure_gain), .code(code_blue)
  );

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // a request held at vld[DIV_STEPS] is not dropped during a stall
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS] && !en |=> vld[DIV_STEPS])
    else $error("request lost in stalled pipeline");

  // at most one request enters per cycle
  a_one_in: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) <= $countones($past(vld)) + 1)
    else $error("request count grew by more than one");

endmodule
`default_nettype wire
